// File: hw/rtl/dflf_pkg.sv
// shared types and constants for the dropout fill block
`default_nettype none
package dflf_pkg;
    localparam int unsigned CHANNELS = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [CHANNELS-1:0] t_mask;

    typedef struct packed {
        t_sample pressure_a;
        t_sample pressure_b;
        t_sample pressure_c;
        t_mask   present_mask;
    } t_in_item;

    typedef struct packed {
        t_sample fixed_a;
        t_sample fixed_b;
        t_sample fixed_c;
        t_mask   replaced_mask;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_FIT,
        ST_OUT
    } t_state;

    // fit phases: numerators, slope divide, intercept divide
    typedef logic [3:0] t_phase;
    localparam t_phase PH_NUM  = 4'd0;
    localparam t_phase PH_LOAD = 4'd1;   // load slope numerator
    localparam t_phase PH_SWAP = 4'd6;   // store slope, load intercept numerator
    localparam t_phase PH_LAST = 4'd11;  // store intercept

    // lane control from the sequencer
    typedef struct packed {
        logic   clear;
        logic   accum;
        logic   update;
        t_phase phase;
    } t_lane_ctrl;

    // saturate a wide signed value to 32 bits
    function automatic t_sample sat32(input logic signed [127:0] v);
        t_sample r;
        if (v > 128'(signed'(SAT_MAX))) begin
            r = SAT_MAX;
        end else if (v < 128'(signed'(SAT_MIN))) begin
            r = SAT_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/dflf_if.sv
// valid/ready channel carrying one payload
`default_nettype none
interface dflf_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/dropout_fill_linear_fit.sv
// top level of the dropout fill block
`default_nettype none
// dropout fill by least squares linear extrapolation. each transfer carries
// three q15.16 pressures and a node present mask; a present channel reading
// exactly zero is replaced by slope*(WINDOW-1)+intercept, saturated. three
// identical lanes, one per channel, each keep a window ram of WINDOW samples.
// once the window is full every item triggers a refit: the lanes walk the
// oldest WINDOW-1 entries through their ram read port, one entry a cycle,
// accumulating sum y and sum x*y, then divide against constant denominators
// by reciprocal multiplication, one 32x32 partial product a cycle.
// once the window is full an item is followed by the ram read walk and the
// fit, and no new item is taken until the fit is done; before that no refit
// is run. the window shift is done by a ring pointer rather than moving
// data. a result may leave in the same cycle as the next transfer is taken;
// one left waiting at the output holds the input off.
module dropout_fill_linear_fit #(
    parameter int unsigned WINDOW = 8
) (
    input wire i_clk,
    input wire i_rst_n,
    dflf_if.sink   s_in,
    dflf_if.source m_out
);
    import dflf_pkg::*;
    localparam int unsigned AW = $clog2(WINDOW);
    localparam int unsigned CW = $clog2(WINDOW + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_base;   // ring slot of logical entry 0
    logic [AW-1:0] r_step;
    t_phase r_ph;
    t_mask r_fit;
    t_out_item r_out;
    logic r_ovalid;
    logic [AW-1:0] pos, raddr, waddr;
    t_lane_ctrl ctrl;
    t_sample smp [CHANNELS];
    t_sample val [CHANNELS];
    logic rep [CHANNELS];
    logic acc_q;

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] b,
                                           input logic [CW-1:0] o);
        logic [CW:0] s;
        s = (CW+1)'(b) + (CW+1)'(o);
        if (s >= (CW+1)'(WINDOW)) begin
            s = s - (CW+1)'(WINDOW);
        end
        return s[AW-1:0];
    endfunction

    assign smp[0] = s_in.data.pressure_a;
    assign smp[1] = s_in.data.pressure_b;
    assign smp[2] = s_in.data.pressure_c;
    assign pos = ring(r_base, (r_fill >= CW'(WINDOW)) ? CW'(WINDOW - 1) : r_fill);
    assign waddr = pos;
    assign raddr = ring(r_base, CW'(r_step));
    assign s_in.ready = (r_state == ST_IDLE) && (!r_ovalid || m_out.ready);
    wire take = s_in.valid && s_in.ready;
    wire full_now = (r_fill >= CW'(WINDOW - 1));

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_lane
            dflf_lane #(.WINDOW(WINDOW)) u_lane (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl),
                .i_fit_en(r_fit[g]), .i_wr(take), .i_waddr(waddr),
                .i_raddr(raddr), .i_x(r_step),
                .i_present(s_in.data.present_mask[g]),
                .i_sample(smp[g]), .o_value(val[g]), .o_replaced(rep[g])
            );
        end
    endgenerate

    // sequencer: walk reads entries 0..WINDOW-1, ram read data is registered
    always_comb begin
        n_state = r_state;
        ctrl = '0;
        ctrl.accum = acc_q;
        ctrl.phase = r_ph;
        case (r_state)
            ST_IDLE: begin
                if (take && full_now) begin
                    n_state = ST_ACCUM;
                    ctrl.clear = 1'b1;
                end
            end
            ST_ACCUM: begin
                if (r_step == AW'(WINDOW - 1)) begin
                    n_state = ST_FIT;
                end
            end
            ST_FIT: begin
                ctrl.accum = 1'b0;
                ctrl.update = 1'b1;
                if (r_ph == PH_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill <= '0;
            r_base <= '0;
            r_step <= '0;
            r_ph <= '0;
            r_fit <= '0;
            r_ovalid <= 1'b0;
            acc_q <= 1'b0;
        end else begin
            r_state <= n_state;
            acc_q <= (r_state == ST_ACCUM);
            if (m_out.valid && m_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (take) begin
                r_ovalid <= 1'b1;
                r_fit <= s_in.data.present_mask;
                r_step <= '0;
                if (!full_now) begin
                    r_fill <= r_fill + CW'(1);
                end
            end else if (r_state == ST_ACCUM) begin
                r_step <= r_step + AW'(1);
            end else if (r_state == ST_FIT) begin
                if (r_ph == PH_LAST) begin
                    r_ph <= '0;
                    // drop the oldest entry
                    r_base <= ring(r_base, CW'(1));
                end else begin
                    r_ph <= r_ph + t_phase'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.fixed_a <= val[0];
            r_out.fixed_b <= val[1];
            r_out.fixed_c <= val[2];
            r_out.replaced_mask <= {rep[2], rep[1], rep[0]};
        end
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data = r_out;
endmodule
`default_nettype wire

// File: hw/rtl/dflf_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module dflf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/dflf_lane.sv
// one channel: window ram, fit accumulators, solver and fill estimate
`default_nettype none
module dflf_lane #(
    parameter int unsigned WINDOW = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dflf_pkg::t_lane_ctrl i_ctrl,
    input  wire                 i_fit_en,
    input  wire                 i_wr,
    input  wire [$clog2(WINDOW)-1:0] i_waddr,
    input  wire [$clog2(WINDOW)-1:0] i_raddr,
    input  wire [$clog2(WINDOW)-1:0] i_x,
    input  wire                 i_present,
    input  dflf_pkg::t_sample   i_sample,
    output dflf_pkg::t_sample   o_value,
    output logic                o_replaced
);
    import dflf_pkg::*;
    localparam longint N = WINDOW - 1;
    localparam longint SX = N * (N + 1) / 2;
    localparam longint SX2 = N * (N + 1) * (2 * N + 1) / 6;
    localparam longint D = N * SX2 - SX * SX;
    localparam int unsigned ACC_W = 48;
    // divide by reciprocal multiplication, exact for quotients below 2^32
    localparam int unsigned L = $clog2(D);
    localparam int unsigned K = 32 + 2 * L;
    localparam logic [127:0] RECIP = ((128'd1 << K) + 128'(D) - 128'd1) / 128'(D);
    localparam logic [63:0] LIM = 64'(D) << 32;

    logic signed [ACC_W-1:0] r_sy, r_sxy;
    t_sample r_slope, r_icpt;
    t_sample rd;
    logic signed [63:0] est;
    logic signed [63:0] num_s, num_i;
    logic signed [63:0] r_num_s, r_num_i;
    logic signed [63:0] num_sel;
    logic [63:0] mag;
    logic [63:0] r_mag;
    logic r_neg, r_ovf;
    logic [127:0] r_prod;
    logic [1:0] pp_idx;
    logic [31:0] pp_a, pp_b;
    logic [63:0] pp;
    logic [127:0] pp_sh;
    logic [DATA_W-1:0] q;
    t_sample quo;
    logic signed [39:0] prod;

    // fill estimate at x = window-1
    always_comb begin
        est = 64'(r_slope) * 64'(N) + 64'(r_icpt);
        o_replaced = i_present && (i_sample == '0);
        o_value = o_replaced ? sat32(128'(est)) : i_sample;
    end

    dflf_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW)) u_ram (
        .i_clk(i_clk), .i_we(i_wr), .i_waddr(i_waddr), .i_wdata(o_value),
        .i_raddr(i_raddr), .o_rdata(rd)
    );

    assign prod = 40'(signed'(rd)) * signed'(40'({1'b0, i_x}));
    assign num_s = 64'(N) * 64'(r_sxy) - 64'(SX) * 64'(r_sy);
    assign num_i = 64'(r_sy) * 64'(SX2) - 64'(SX) * 64'(r_sxy);

    // magnitude of the numerator about to be divided
    always_comb begin
        num_sel = (i_ctrl.phase == PH_SWAP) ? r_num_i : r_num_s;
        mag = num_sel[63] ? -num_sel : num_sel;
    end

    // one 32x32 partial product of magnitude and reciprocal a cycle
    always_comb begin
        pp_idx = (i_ctrl.phase > PH_SWAP) ? 2'(i_ctrl.phase - PH_SWAP - 4'd1)
                                          : 2'(i_ctrl.phase - PH_LOAD - 4'd1);
        pp_a = pp_idx[0] ? r_mag[63:32] : r_mag[31:0];
        pp_b = pp_idx[1] ? RECIP[63:32] : RECIP[31:0];
        pp = 64'(pp_a) * 64'(pp_b);
        pp_sh = 128'(pp) << {2'({1'b0, pp_idx[0]}) + 2'({1'b0, pp_idx[1]}), 5'd0};
    end

    // signed, saturated quotient truncated toward zero
    always_comb begin
        q = r_prod[K +: DATA_W];
        if (r_ovf || q[DATA_W-1]) begin
            quo = r_neg ? SAT_MIN : SAT_MAX;
        end else if (r_neg) begin
            quo = -q;
        end else begin
            quo = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope <= '0;
            r_icpt <= '0;
        end else begin
            if (i_ctrl.clear) begin
                r_sy <= '0;
                r_sxy <= '0;
            end else if (i_ctrl.accum) begin
                r_sy <= r_sy + ACC_W'(signed'(rd));
                r_sxy <= r_sxy + ACC_W'(prod);
            end
            if (i_ctrl.update) begin
                case (i_ctrl.phase)
                    PH_NUM: begin
                        r_num_s <= num_s;
                        r_num_i <= num_i;
                    end
                    PH_LOAD, PH_SWAP: begin
                        if (i_ctrl.phase == PH_SWAP && i_fit_en) begin
                            r_slope <= quo;
                        end
                        r_neg <= num_sel[63];
                        r_ovf <= (mag >= LIM);
                        r_mag <= mag;
                        r_prod <= '0;
                    end
                    PH_LAST: begin
                        if (i_fit_en) begin
                            r_icpt <= quo;
                        end
                    end
                    default: r_prod <= r_prod + pp_sh;
                endcase
            end
        end
    end
endmodule
`default_nettype wire
